// File: hdl/tess_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_pkg: shared types and codes for the two-ended shared stack
// Item layouts, opcodes and result status codes.
// ----------------------------------------------------------------------------
package tess_pkg;

	localparam int WORD_W    = 32;
	localparam int DEPTH_DEF = 16;

	// opcodes
	localparam logic [2:0] OP_PUSH_L = 3'd0;
	localparam logic [2:0] OP_POP_L  = 3'd1;
	localparam logic [2:0] OP_LIST_L = 3'd2;
	localparam logic [2:0] OP_PUSH_R = 3'd3;
	localparam logic [2:0] OP_POP_R  = 3'd4;
	localparam logic [2:0] OP_LIST_R = 3'd5;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [WORD_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data_word;
		logic [1:0]               status;
		logic                     last_of_run;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/tess_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tess_store: word store shared by both stacks
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tess_store import tess_pkg::*; #(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/two_ended_shared_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_ended_shared_stack: two stacks in one word store
// Left stack grows up from entry 0, right stack grows down from DEPTH-1.
//
//   channel   ports                  handshake
//   command   start, busy, cmd       taken when start is high and busy low
//   result    strobe, result         valid for one cycle, always taken
//
// Push, overflow, underflow and empty list: result in the cycle after the item,
// busy stays low, so these items can follow every cycle.
// Pop: bound by the store's registered read; busy for one cycle.
// List of n entries: one store read per entry; busy until the
// last read is out. Opcodes 6 and 7 are taken and give no result.
// Reset clears both counts; the store itself is not cleared.
// ----------------------------------------------------------------------------
module two_ended_shared_stack import tess_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      strobe,
	output result_t   result
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  lcnt_q;
	logic [CNT_W-1:0]  rcnt_q;
	logic              strobe_q;
	result_t           result_q;
	logic [ADDR_W-1:0] idx_q;
	logic [CNT_W-1:0]  n_q;
	logic              side_q;

	logic              accept;
	logic [CNT_W:0]    fill;
	logic              full;
	logic [CNT_W-1:0]  pop_l_idx;
	logic [CNT_W-1:0]  pop_r_idx;
	logic [ADDR_W-1:0] nxt_idx;
	logic              list_last;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [WORD_W-1:0] rdata;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign result    = result_q;

	assign fill      = {1'b0, lcnt_q} + {1'b0, rcnt_q};
	assign full      = fill >= (CNT_W + 1)'(DEPTH);
	assign pop_l_idx = lcnt_q - CNT_W'(1);
	assign pop_r_idx = CNT_W'(DEPTH) - rcnt_q;
	assign nxt_idx   = idx_q + ADDR_W'(1);
	assign list_last = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;

	// write on a push that fits
	always_comb begin
		we    = 1'b0;
		waddr = lcnt_q[ADDR_W-1:0];
		if (accept && !full) begin
			case (cmd.opcode)
				OP_PUSH_L: begin
					we    = 1'b1;
					waddr = lcnt_q[ADDR_W-1:0];
				end
				OP_PUSH_R: begin
					we    = 1'b1;
					waddr = ADDR_W'(DEPTH - 1) - rcnt_q[ADDR_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// pick the read address: pop or first list entry on accept, next entry in a list
	always_comb begin
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				case (cmd.opcode)
					OP_POP_L:  raddr = pop_l_idx[ADDR_W-1:0];
					OP_POP_R:  raddr = pop_r_idx[ADDR_W-1:0];
					OP_LIST_R: raddr = ADDR_W'(DEPTH - 1);
					default:   raddr = '0;
				endcase
			end
			S_LIST: raddr = side_q ? (ADDR_W'(DEPTH - 1) - nxt_idx) : nxt_idx;
			default: raddr = '0;
		endcase
	end

	tess_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.push_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequence the item, update counts, raise the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lcnt_q   <= '0;
			rcnt_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.opcode)
							OP_PUSH_L: begin
								strobe_q <= 1'b1;
								if (!full) lcnt_q <= lcnt_q + CNT_W'(1);
							end
							OP_PUSH_R: begin
								strobe_q <= 1'b1;
								if (!full) rcnt_q <= rcnt_q + CNT_W'(1);
							end
							OP_POP_L: begin
								if (lcnt_q == '0) begin
									strobe_q <= 1'b1;
								end else begin
									lcnt_q  <= pop_l_idx;
									state_q <= S_POP;
								end
							end
							OP_POP_R: begin
								if (rcnt_q == '0) begin
									strobe_q <= 1'b1;
								end else begin
									rcnt_q  <= rcnt_q - CNT_W'(1);
									state_q <= S_POP;
								end
							end
							OP_LIST_L: begin
								if (lcnt_q == '0) strobe_q <= 1'b1;
								else state_q <= S_LIST;
							end
							OP_LIST_R: begin
								if (rcnt_q == '0) strobe_q <= 1'b1;
								else state_q <= S_LIST;
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_LIST: begin
					strobe_q <= 1'b1;
					if (list_last) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// build the result item and hold the list walk position
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					result_q.data_word   <= '0;
					result_q.status      <= ST_OK;
					result_q.last_of_run <= 1'b1;
					idx_q                <= '0;
					n_q                  <= (cmd.opcode == OP_LIST_R) ? rcnt_q : lcnt_q;
					side_q               <= (cmd.opcode == OP_LIST_R);
					case (cmd.opcode)
						OP_PUSH_L, OP_PUSH_R: begin
							if (full) result_q.status <= ST_OVERFLOW;
						end
						OP_POP_L: begin
							if (lcnt_q == '0) result_q.status <= ST_UNDERFLOW;
						end
						OP_POP_R: begin
							if (rcnt_q == '0) result_q.status <= ST_UNDERFLOW;
						end
						OP_LIST_L: begin
							if (lcnt_q == '0) result_q.status <= ST_EMPTY;
						end
						OP_LIST_R: begin
							if (rcnt_q == '0) result_q.status <= ST_EMPTY;
						end
						default: ;
					endcase
				end
			end
			S_POP: begin
				result_q.data_word   <= rdata;
				result_q.status      <= ST_OK;
				result_q.last_of_run <= 1'b1;
			end
			S_LIST: begin
				result_q.data_word   <= rdata;
				result_q.status      <= ST_OK;
				result_q.last_of_run <= list_last;
				idx_q                <= nxt_idx;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
